FILE: rtl/paged_framebuffer_span_filler_unit_defines.svh
// Assertion macros shared by the span filler RTL.
`ifndef PAGED_FRAMEBUFFER_SPAN_FILLER_UNIT_DEFINES_SVH
`define PAGED_FRAMEBUFFER_SPAN_FILLER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PFSF_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pfsf: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define PFSF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pfsf: next-cycle check failed");

`endif

FILE: rtl/pfsf_pkg.sv
// Types, command codes and page code mapping for the span filler.
package pfsf_pkg;

	typedef logic [1:0]         page_t;
	typedef logic [7:0]         code_t;
	typedef logic [7:0]         pixel_t;
	typedef logic signed [15:0] coord_t;

	typedef enum logic [2:0] {
		CMD_FILL_FWD  = 3'd0,
		CMD_FILL_REV  = 3'd1,
		CMD_FILL_PAGE = 3'd2,
		CMD_COPY      = 3'd3,
		CMD_SELECT    = 3'd4,
		CMD_SHOW      = 3'd5,
		CMD_READ      = 3'd6
	} cmd_t;

	// special page codes
	localparam code_t CODE_SHOWN  = 8'hfe;
	localparam code_t CODE_HIDDEN = 8'hff;
	localparam code_t COPY_MASK   = 8'hbf;
	localparam code_t CODE_PAGE0  = 8'h00;
	localparam code_t CODE_PAGE1A = 8'h01;
	localparam code_t CODE_PAGE1B = 8'h02;
	localparam code_t CODE_PAGE2  = 8'h03;

	localparam int    PAGE_COUNT   = 3;
	localparam page_t RESET_SHOWN  = 2'd2;
	localparam page_t RESET_HIDDEN = 2'd1;
	localparam page_t RESET_DRAW   = 2'd2;

	// page code to physical page
	function automatic page_t map_code(code_t code, page_t shown, page_t hidden);
		page_t p;
		unique case (code)
			CODE_PAGE0:               p = 2'd0;
			CODE_PAGE1A, CODE_PAGE1B: p = 2'd1;
			CODE_PAGE2:               p = 2'd2;
			CODE_SHOWN:               p = shown;
			CODE_HIDDEN:              p = hidden;
			default:                  p = 2'd0;
		endcase
		return p;
	endfunction

	// copy operands drop bit 6 of ordinary codes first
	function automatic page_t map_copy_code(code_t code, page_t shown, page_t hidden);
		code_t c;
		c = (code < CODE_SHOWN) ? (code & COPY_MASK) : code;
		return map_code(c, shown, hidden);
	endfunction

endpackage

FILE: rtl/pfsf_req_if.sv
// Command channel: valid/ready handshake carrying one command beat.
interface pfsf_req_if import pfsf_pkg::*; ();
	logic   valid;
	logic   ready;
	logic   [2:0] command;
	code_t  page_code;
	code_t  dest_code;
	coord_t x_pos;
	coord_t y_pos;
	coord_t span_length;
	pixel_t pixel_value;

	modport source (output valid, command, page_code, dest_code, x_pos, y_pos,
		span_length, pixel_value, input ready);
	modport sink (input valid, command, page_code, dest_code, x_pos, y_pos,
		span_length, pixel_value, output ready);
endinterface

FILE: rtl/pfsf_rsp_if.sv
// Result channel: valid/ready handshake carrying one status beat.
interface pfsf_rsp_if import pfsf_pkg::*; ();
	logic   valid;
	logic   ready;
	page_t  visible_index;
	page_t  selected_index;
	pixel_t read_value;
	logic   rejected;

	modport source (output valid, visible_index, selected_index, read_value, rejected,
		input ready);
	modport sink (input valid, visible_index, selected_index, read_value, rejected,
		output ready);
endinterface

FILE: rtl/paged_framebuffer_span_filler_unit.sv
// Paged framebuffer span filler: three byte pages, span/page fills, copy, show, read.
//
//  channel | dir | beat contents
//  --------+-----+------------------------------------------------------------
//  req     | in  | command, page_code, dest_code, x_pos, y_pos, span_length,
//          |     | pixel_value
//  rsp     | out | visible_index, selected_index, read_value, rejected
//
// Span fill: pixels are written one per cycle through the single write port of
// the page memory. Page fill: W*H pixels, written the same way. Copy: W*H pixels,
// one read and one write per cycle, each write in the cycle after its read; none
// is copied when source and destination are the same page. Select, show, unused
// code and rejected commands go from clip to result. Pixel read: one registered read.
// req.ready is high only while the sequencer is idle; a finished result waits in
// the output register and a new command is taken while it waits.
// Reset clears control state only; page memory holds garbage until written.
`include "paged_framebuffer_span_filler_unit_defines.svh"

module paged_framebuffer_span_filler_unit import pfsf_pkg::*; #(
	parameter int PAGE_WIDTH  = 304,
	parameter int PAGE_HEIGHT = 192
) (
	input  logic        clk,
	input  logic        arst_n,
	pfsf_req_if.sink    req,
	pfsf_rsp_if.source  rsp
);

	localparam int PAGE_SIZE = PAGE_WIDTH * PAGE_HEIGHT;
	localparam int MEM_DEPTH = PAGE_COUNT * PAGE_SIZE;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);
	localparam int CNT_W     = $clog2(PAGE_SIZE + 1);
	localparam int X_W       = $clog2(PAGE_WIDTH);
	localparam int Y_W       = $clog2(PAGE_HEIGHT);

	localparam logic signed [17:0] W_S = 18'(PAGE_WIDTH);
	localparam logic signed [17:0] H_S = 18'(PAGE_HEIGHT);
	localparam logic [ADDR_W-1:0]  BASE1 = ADDR_W'(PAGE_SIZE);
	localparam logic [ADDR_W-1:0]  BASE2 = ADDR_W'(2 * PAGE_SIZE);
	localparam logic [CNT_W-1:0]   PAGE_CNT = CNT_W'(PAGE_SIZE);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_CLIP   = 7'b0000010,
		S_ADDR   = 7'b0000100,
		S_FILL   = 7'b0001000,
		S_COPY   = 7'b0010000,
		S_READ   = 7'b0100000,
		S_RESULT = 7'b1000000
	} state_t;

	function automatic logic [ADDR_W-1:0] page_base(page_t p);
		logic [ADDR_W-1:0] b;
		unique case (p)
			2'd0:    b = '0;
			2'd1:    b = BASE1;
			default: b = BASE2;
		endcase
		return b;
	endfunction

	state_t            state_q;
	page_t             shown_q, hidden_q, draw_q;
	logic              pend_s1;
	logic              rsp_valid_q;

	// captured command
	logic [2:0]        cmd_q;
	code_t             code_q, dcode_q;
	coord_t            x_q, y_q, len_q;
	pixel_t            colour_q;

	// datapath
	page_t             page_q;
	logic              rej_q;
	logic              dir_q;
	logic [X_W-1:0]    col_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [ADDR_W-1:0] row_off_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] dst_q;
	pixel_t            rd_q;

	page_t             vis_q, sel_q;
	pixel_t            rdval_q;
	logic              rejo_q;

	logic [7:0]        mem_q [MEM_DEPTH];

	logic              accept;
	logic              rsp_load;
	page_t             copy_src, copy_dst;

	assign accept   = req.valid && req.ready;
	assign rsp_load = (state_q == S_RESULT) && (!rsp_valid_q || rsp.ready);
	assign copy_src = map_copy_code(code_q, shown_q, hidden_q);
	assign copy_dst = map_copy_code(dcode_q, shown_q, hidden_q);

	// span clipping, read bounds
	logic signed [17:0] xs, ys, cs;
	logic signed [17:0] fx1, fc1, fc2;
	logic signed [17:0] rc1, rc2, rx2;
	logic               fwd_rej, rev_rej, rd_rej;
	logic               clip_rej;
	logic signed [17:0] clip_col, clip_cnt;

	always_comb begin
		xs = 18'(x_q);
		ys = 18'(y_q);
		cs = 18'(len_q);

		fwd_rej = (xs > W_S - 18'sd1) || (ys < 18'sd0) || (ys > H_S - 18'sd1);
		rev_rej = (xs < 18'sd0) || (ys < 18'sd0) || (ys > H_S - 18'sd1);
		rd_rej  = (xs < 18'sd0) || (xs > W_S - 18'sd1) || (ys < 18'sd0) ||
			(ys > H_S - 18'sd1);

		// forward: pull start to column 0, then cap at the right edge
		fx1 = (xs < 18'sd0) ? 18'sd0 : xs;
		fc1 = (xs < 18'sd0) ? cs + xs : cs;
		fc2 = (fx1 + fc1 > W_S - 18'sd1) ? W_S - fx1 : fc1;

		// reverse: stop at column 0, then pull start to the right edge
		rc1 = (xs - cs < 18'sd0) ? xs + 18'sd1 : cs;
		rc2 = (xs > W_S - 18'sd1) ? rc1 - (xs - (W_S - 18'sd1)) : rc1;
		rx2 = (xs > W_S - 18'sd1) ? W_S - 18'sd1 : xs;

		priority case (cmd_q)
			CMD_FILL_FWD: begin
				clip_rej = fwd_rej;
				clip_col = fx1;
				clip_cnt = fc2;
			end
			CMD_FILL_REV: begin
				clip_rej = rev_rej;
				clip_col = rx2;
				clip_cnt = rc2;
			end
			CMD_READ: begin
				clip_rej = rd_rej;
				clip_col = xs;
				clip_cnt = 18'sd0;
			end
			default: begin
				clip_rej = 1'b0;
				clip_col = 18'sd0;
				clip_cnt = 18'sd0;
			end
		endcase
		if (clip_cnt < 18'sd0)
			clip_cnt = 18'sd0;
	end

	// sequencer and page registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			shown_q     <= RESET_SHOWN;
			hidden_q    <= RESET_HIDDEN;
			draw_q      <= RESET_DRAW;
			pend_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			// result register: load a new beat or drop the one taken
			if (rsp_load)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
			pend_s1 <= (state_q == S_COPY) && (cnt_q != '0);
			unique case (state_q)
				S_IDLE: begin
					if (accept)
						state_q <= S_CLIP;
				end
				S_CLIP: begin
					priority case (cmd_q)
						CMD_FILL_FWD, CMD_FILL_REV, CMD_READ:
							state_q <= clip_rej ? S_RESULT : S_ADDR;
						CMD_FILL_PAGE:
							state_q <= S_FILL;
						CMD_COPY:
							state_q <= S_COPY;
						CMD_SELECT: begin
							draw_q  <= map_code(code_q, shown_q, hidden_q);
							state_q <= S_RESULT;
						end
						CMD_SHOW: begin
							if (code_q == CODE_HIDDEN) begin
								shown_q  <= hidden_q;
								hidden_q <= shown_q;
							end else if (code_q != CODE_SHOWN) begin
								shown_q <= map_code(code_q, shown_q, hidden_q);
							end
							state_q <= S_RESULT;
						end
						default:
							state_q <= S_RESULT;
					endcase
				end
				S_ADDR: begin
					state_q <= (cmd_q == CMD_READ) ? S_READ : S_FILL;
				end
				S_FILL: begin
					if (cnt_q == '0)
						state_q <= S_RESULT;
				end
				S_COPY: begin
					if (cnt_q == '0 && !pend_s1)
						state_q <= S_RESULT;
				end
				S_READ: begin
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (rsp_load)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath: address and count unit shared by all commands
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= req.command;
			code_q   <= req.page_code;
			dcode_q  <= req.dest_code;
			x_q      <= req.x_pos;
			y_q      <= req.y_pos;
			len_q    <= req.span_length;
			colour_q <= req.pixel_value;
		end
		unique case (state_q)
			S_CLIP: begin
				row_off_q <= ADDR_W'(y_q[Y_W-1:0]) * ADDR_W'(PAGE_WIDTH);
				rej_q     <= clip_rej;
				col_q     <= X_W'(clip_col);
				dir_q     <= (cmd_q == CMD_FILL_REV);
				page_q    <= (cmd_q == CMD_READ) ?
					map_code(code_q, shown_q, hidden_q) : draw_q;
				priority case (cmd_q)
					CMD_FILL_PAGE: begin
						cnt_q  <= PAGE_CNT;
						addr_q <= page_base(draw_q);
					end
					CMD_COPY: begin
						cnt_q  <= (copy_src != copy_dst) ? PAGE_CNT : '0;
						addr_q <= page_base(copy_src);
						dst_q  <= page_base(copy_dst);
					end
					default: begin
						cnt_q <= CNT_W'(clip_cnt);
					end
				endcase
			end
			S_ADDR: begin
				addr_q <= page_base(page_q) + row_off_q + ADDR_W'(col_q);
			end
			S_FILL: begin
				if (cnt_q != '0) begin
					addr_q <= dir_q ? addr_q - ADDR_W'(1) : addr_q + ADDR_W'(1);
					cnt_q  <= cnt_q - CNT_W'(1);
				end
			end
			S_COPY: begin
				if (cnt_q != '0) begin
					addr_q <= addr_q + ADDR_W'(1);
					cnt_q  <= cnt_q - CNT_W'(1);
				end
				if (pend_s1)
					dst_q <= dst_q + ADDR_W'(1);
			end
			S_RESULT: begin
				if (rsp_load) begin
					vis_q   <= shown_q;
					sel_q   <= draw_q;
					rdval_q <= (cmd_q == CMD_READ && !rej_q) ? rd_q : '0;
					rejo_q  <= rej_q;
				end
			end
			default: begin
			end
		endcase
	end

	// page memory: one write port, one registered read port
	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] mem_waddr;
	pixel_t            mem_wdata;

	assign mem_we    = ((state_q == S_FILL) && (cnt_q != '0)) || pend_s1;
	assign mem_re    = ((state_q == S_COPY) && (cnt_q != '0)) || (state_q == S_READ);
	assign mem_waddr = pend_s1 ? dst_q : addr_q;
	assign mem_wdata = pend_s1 ? rd_q : colour_q;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem_q[mem_waddr] <= mem_wdata;
		if (mem_re)
			rd_q <= mem_q[addr_q];
	end

	assign req.ready          = (state_q == S_IDLE);
	assign rsp.valid          = rsp_valid_q;
	assign rsp.visible_index  = vis_q;
	assign rsp.selected_index = sel_q;
	assign rsp.read_value     = rdval_q;
	assign rsp.rejected       = rejo_q;

	// checks
	`PFSF_ASSERT_NEXT(a_accept_to_clip, accept, state_q == S_CLIP)
	`PFSF_ASSERT_NOW(a_fill_has_count, (state_q == S_FILL) && mem_we && !pend_s1, cnt_q != '0)
	`PFSF_ASSERT_NOW(a_copy_write_in_copy, pend_s1, state_q == S_COPY)
	`PFSF_ASSERT_NOW(a_reject_no_data, rsp_valid_q && rejo_q, rdval_q == '0)

endmodule
